[src/idll_pkg.sv]
// Shared types, codes and constants of the indexed doubly linked list.
package idll_pkg;

  // Node ids are 11 bits wide; id 0 means "none"
  localparam int ID_W      = 11;
  localparam int ID_MAX    = (1 << ID_W) - 1;
  localparam int NODES_DEF = 1024;

  typedef logic [ID_W-1:0] id_t;

  // Mode codes of an input word
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_WALK   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ANCHOR = 2'd1,
    ST_BAD_NEW  = 2'd2,
    ST_NO_QUERY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_COMMIT
  } state_t;

  // Entry of the successor store: membership bit packed with the link
  typedef struct packed {
    logic listed;
    id_t  nxt;
  } nlink_t;

  // Read request: both stores at the anchor, successor store at the new id
  typedef struct packed {
    logic en;
    id_t  a_id;
    id_t  b_id;
  } rd_req_t;

  typedef struct packed {
    nlink_t n_a;
    nlink_t n_b;
    id_t    p_a;
  } rd_data_t;

  // One write to each store per cycle
  typedef struct packed {
    logic   n_en;
    id_t    n_addr;
    nlink_t n_data;
    logic   p_en;
    id_t    p_addr;
    id_t    p_data;
  } wr_t;

endpackage

[src/idll_store.sv]
// Successor and predecessor stores: synchronous memories with registered reads.
module idll_store #(
  parameter int DEPTH = idll_pkg::NODES_DEF + 1
) (
  input  logic               clk,
  input  idll_pkg::rd_req_t  rd_req,
  input  idll_pkg::wr_t      wr,
  output idll_pkg::rd_data_t rd_data
);
  import idll_pkg::*;

  localparam int AW = $clog2(DEPTH);

  nlink_t nmem [DEPTH];
  id_t    pmem [DEPTH];

  nlink_t n_a_r;
  nlink_t n_b_r;
  id_t    p_a_r;

  // Successor store: one write port, two read ports
  always_ff @(posedge clk) begin
    if (wr.n_en) begin
      nmem[wr.n_addr[AW-1:0]] <= wr.n_data;
    end
    if (rd_req.en) begin
      n_a_r <= nmem[rd_req.a_id[AW-1:0]];
      n_b_r <= nmem[rd_req.b_id[AW-1:0]];
    end
  end

  // Predecessor store: one write port, one read port
  always_ff @(posedge clk) begin
    if (wr.p_en) begin
      pmem[wr.p_addr[AW-1:0]] <= wr.p_data;
    end
    if (rd_req.en) begin
      p_a_r <= pmem[rd_req.a_id[AW-1:0]];
    end
  end

  assign rd_data.n_a = n_a_r;
  assign rd_data.n_b = n_b_r;
  assign rd_data.p_a = p_a_r;

endmodule

[src/idll_ctrl.sv]
// Sequencer: clearing pass, checks, link updates and the result register.
module idll_ctrl #(
  parameter int NODES = idll_pkg::NODES_DEF,
  parameter int DEPTH = idll_pkg::NODES_DEF + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  idll_pkg::id_t       in_new_node,
  input  idll_pkg::id_t       in_anchor_node,
  input  logic                in_insert_after,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output idll_pkg::id_t       out_next_node,
  output idll_pkg::rd_req_t   rd_req,
  output idll_pkg::wr_t       wr,
  input  idll_pkg::rd_data_t  rd_data
);
  import idll_pkg::*;

  localparam int AW = $clog2(DEPTH);

  state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r;

  // Captured input word
  logic mode_r;
  id_t  nw_r;
  id_t  anc_r;
  logic after_r;

  id_t  first_r;
  id_t  nb_r;
  logic nb_ok_r;

  logic    out_valid_r;
  status_t out_status_r;
  id_t     out_next_r;

  logic    in_fire;
  logic    out_free;
  logic    load;
  logic    anc_ok;
  logic    nw_ok;
  logic    ins_ok;
  id_t     nb;
  logic    nb_ok;
  status_t res_status;
  id_t     res_next;

  // Id lies in 1..NODES
  function automatic logic id_in_range(input id_t id);
    return (id != '0) && (32'(id) <= NODES);
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Checks on the registered read data
  always_comb begin
    anc_ok = id_in_range(anc_r) && rd_data.n_a.listed;
    nw_ok  = id_in_range(nw_r) && !rd_data.n_b.listed;
    nb     = after_r ? rd_data.n_a.nxt : rd_data.p_a;
    nb_ok  = id_in_range(nb);
    ins_ok = (mode_r == MODE_INSERT) && anc_ok && nw_ok;
    res_next = '0;
    if (mode_r == MODE_WALK) begin
      if (anc_r == '0) begin
        res_status = ST_OK;
        res_next   = first_r;
      end else if (anc_ok) begin
        res_status = ST_OK;
        res_next   = rd_data.n_a.nxt;
      end else begin
        res_status = ST_NO_QUERY;
      end
    end else if (!anc_ok) begin
      res_status = ST_NO_ANCHOR;
    end else if (!nw_ok) begin
      res_status = ST_BAD_NEW;
    end else begin
      res_status = ST_OK;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (out_free) begin
          state_nxt = ins_ok ? S_COMMIT : S_IDLE;
        end
      end
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // Memory ports and result load
  always_comb begin
    rd_req.en   = in_fire;
    rd_req.a_id = id_in_range(in_anchor_node) ? in_anchor_node : '0;
    rd_req.b_id = id_in_range(in_new_node) ? in_new_node : '0;
    wr   = '0;
    load = 1'b0;
    case (state_r)
      S_CLEAR: begin
        // only node 1 is listed after reset, with no neighbours
        wr.n_en          = 1'b1;
        wr.n_addr        = ID_W'(cnt_r);
        wr.n_data.listed = (cnt_r == AW'(1));
        wr.n_data.nxt    = '0;
        wr.p_en          = 1'b1;
        wr.p_addr        = ID_W'(cnt_r);
        wr.p_data        = '0;
      end
      S_LOOK: begin
        load = out_free;
        if (out_free && ins_ok) begin
          // links of the new node
          wr.n_en          = 1'b1;
          wr.n_addr        = nw_r;
          wr.n_data.listed = 1'b1;
          wr.n_data.nxt    = after_r ? nb : anc_r;
          wr.p_en          = 1'b1;
          wr.p_addr        = nw_r;
          wr.p_data        = after_r ? anc_r : nb;
        end
      end
      S_COMMIT: begin
        // relink anchor and old neighbour to the new node
        wr.n_data.listed = 1'b1;
        wr.n_data.nxt    = nw_r;
        wr.p_data        = nw_r;
        if (after_r) begin
          wr.n_en   = 1'b1;
          wr.n_addr = anc_r;
          wr.p_en   = nb_ok_r;
          wr.p_addr = nb_r;
        end else begin
          wr.p_en   = 1'b1;
          wr.p_addr = anc_r;
          wr.n_en   = nb_ok_r;
          wr.n_addr = nb_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      first_r     <= ID_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        cnt_r <= cnt_r + AW'(1);
      end
      // new node placed before the head becomes the head
      if (load && ins_ok && !nb_ok && !after_r) begin
        first_r <= nw_r;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r  <= in_mode;
      nw_r    <= in_new_node;
      anc_r   <= in_anchor_node;
      after_r <= in_insert_after;
    end
    if (load) begin
      nb_r         <= nb;
      nb_ok_r      <= nb_ok;
      out_status_r <= res_status;
      out_next_r   <= res_next;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_next_node = out_next_r;

endmodule

[src/indexed_doubly_linked_list.sv]
// Top level of the indexed doubly linked list of node ids.
//
// Keeps an ordered list of node ids 1..NODES in two id-indexed memories
// (successor with membership bit, predecessor) plus a head register; the tail
// is the node whose successor is 0.
// An insert word places a new id after or before a listed anchor; a walk word
// returns the head (anchor 0) or the successor of a listed id, 0 past the end.
// Every word gives one result word, loaded into the output register once its
// read data is in and that register is free. A walk or a refused insert needs
// only the memory read; an accepted insert writes the new node's links and then
// relinks the anchor and its old neighbour, as each memory has a single write
// port and an insert changes up to four pointers. After reset a clearing pass
// over all min(NODES, 2047) + 1 entries (1025 by default) of both memories runs
// before the first input word is taken. The result sits in an output register,
// so a new word is taken while the previous result is still waiting.
module indexed_doubly_linked_list #(
  parameter int NODES = idll_pkg::NODES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [10:0]         in_new_node,
  input  logic [10:0]         in_anchor_node,
  input  logic                in_insert_after,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [10:0]         out_next_node
);
  import idll_pkg::*;

  localparam int DEPTH = (NODES < ID_MAX) ? NODES + 1 : ID_MAX + 1;

  rd_req_t  rd_req;
  wr_t      wr;
  rd_data_t rd_data;

  idll_ctrl #(
    .NODES (NODES),
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_new_node     (in_new_node),
    .in_anchor_node  (in_anchor_node),
    .in_insert_after (in_insert_after),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_next_node   (out_next_node),
    .rd_req          (rd_req),
    .wr              (wr),
    .rd_data         (rd_data)
  );

  idll_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_req  (rd_req),
    .wr      (wr),
    .rd_data (rd_data)
  );

endmodule

[dv/testbench.sv]
// Testbench of the indexed doubly linked list: directed table, random words, predictor checks.
module testbench;
  import idll_pkg::*;

  localparam int NODES    = NODES_DEF;
  localparam int WATCHDOG = 5000;
  localparam int N_RANDOM = 950;
  localparam int DIR_ROWS = 25;
  localparam int LONG_HOLD = 200;

  typedef struct packed {
    logic mode;
    id_t  new_node;
    id_t  anchor;
    logic ins_after;
  } word_t;

  typedef struct packed {
    status_t status;
    id_t     next_node;
  } result_t;

  // One row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    logic    mode;
    id_t     new_node;
    id_t     anchor;
    logic    ins_after;
    logic    fixed;
    status_t st;
    id_t     nxt;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [10:0] in_new_node;
  logic [10:0] in_anchor_node;
  logic        in_insert_after;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [10:0] out_next_node;

  indexed_doubly_linked_list #(.NODES(NODES)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_new_node    (in_new_node),
    .in_anchor_node (in_anchor_node),
    .in_insert_after(in_insert_after),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_next_node  (out_next_node)
  );

  // Predicted list state
  id_t  lk_next   [0:NODES];
  id_t  lk_prev   [0:NODES];
  logic lk_listed [0:NODES];
  id_t  head_id;
  id_t  tail_id;

  result_t  pending_res [$];
  id_t      listed_ids [$];
  id_t      last_next;
  dir_row_t dir_tab [DIR_ROWS];

  int errors;
  int words_out;
  int idle_cycles;
  bit burst;

  // Clock, period 20
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit is_listed(id_t id);
    return id != '0 && id <= NODES && lk_listed[id];
  endfunction

  // Apply one word to the predicted list and return its result word
  function automatic result_t advance_list(word_t w);
    result_t r;
    id_t     nb;
    r.status    = ST_OK;
    r.next_node = '0;
    if (w.mode == MODE_INSERT) begin
      if (!is_listed(w.anchor)) begin
        r.status = ST_NO_ANCHOR;
      end else if (w.new_node == '0 || w.new_node > NODES || lk_listed[w.new_node]) begin
        r.status = ST_BAD_NEW;
      end else begin
        lk_listed[w.new_node] = 1'b1;
        if (w.ins_after) begin
          nb = lk_next[w.anchor];
          lk_next[w.new_node] = nb;
          lk_prev[w.new_node] = w.anchor;
          lk_next[w.anchor]   = w.new_node;
          if (nb == '0 || nb > NODES) tail_id = w.new_node;
          else lk_prev[nb] = w.new_node;
        end else begin
          nb = lk_prev[w.anchor];
          lk_prev[w.new_node] = nb;
          lk_next[w.new_node] = w.anchor;
          lk_prev[w.anchor]   = w.new_node;
          if (nb == '0 || nb > NODES) head_id = w.new_node;
          else lk_next[nb] = w.new_node;
        end
      end
    end else if (w.anchor == '0) begin
      r.next_node = head_id;
    end else if (is_listed(w.anchor)) begin
      r.next_node = lk_next[w.anchor];
    end else begin
      r.status = ST_NO_QUERY;
    end
    return r;
  endfunction

  // Offer one word after a random gap; predict once it is taken
  task automatic send_word(input word_t w, input bit fixed, input result_t fixed_res);
    int      gap;
    result_t p;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_mode         <= w.mode;
    in_new_node     <= w.new_node;
    in_anchor_node  <= w.anchor;
    in_insert_after <= w.ins_after;
    in_valid        <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = advance_list(w);
    if (w.mode == MODE_INSERT && p.status == ST_OK) listed_ids.push_back(w.new_node);
    last_next = p.next_node;
    pending_res.push_back(fixed ? fixed_res : p);
  endtask

  // Hold the input back until every outstanding result word is in
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  function automatic id_t pick_listed();
    return listed_ids[$urandom_range(0, listed_ids.size() - 1)];
  endfunction

  // Nonzero id that is not in the list, sometimes above NODES
  function automatic id_t pick_unlisted();
    id_t id;
    id = id_t'($urandom_range(1, 2047));
    while (is_listed(id)) id = id_t'($urandom_range(1, 2047));
    return id;
  endfunction

  // Free id within range; falls back to anything once the list is full
  function automatic id_t pick_free();
    id_t id;
    id = id_t'($urandom_range(1, NODES));
    for (int k = 0; k < 30 && is_listed(id); k++) id = id_t'($urandom_range(1, NODES));
    return id;
  endfunction

  // Result monitor and checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_out <= words_out + 1;
      if (pending_res.size() == 0) begin
        $error("result word with nothing expected: status %0d next_node %0d",
               out_status, out_next_node);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
        if (out_next_node !== e.next_node) begin
          $error("next_node: expected %0d, got %0d", e.next_node, out_next_node);
          errors++;
        end
      end
    end
  end

  // Cycles in which no word is accepted and no result word is taken
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // Receiver: random stall per word, one long hold once the run is under way
  initial begin
    int w;
    bit held;
    held = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (!held && words_out >= 300) begin
        held = 1'b1;
        w = LONG_HOLD;
      end else begin
        w = burst ? 0 : $urandom_range(0, 9);
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Main stimulus
  initial begin
    word_t   w;
    result_t fr;
    id_t     cursor;
    int      r;

    errors      = 0;
    words_out   = 0;
    idle_cycles = 0;
    burst       = 1'b0;
    cursor      = '0;
    last_next   = '0;
    for (int i = 0; i <= NODES; i++) begin
      lk_next[i]   = '0;
      lk_prev[i]   = '0;
      lk_listed[i] = 1'b0;
    end
    lk_listed[1] = 1'b1;
    head_id      = id_t'(1);
    tail_id      = id_t'(1);
    listed_ids.push_back(id_t'(1));

    // mode, new_node, anchor, after, fixed, status, next_node
    dir_tab = '{
      '{MODE_WALK,   11'd0,    11'd0,    1'b0, 1'b1, ST_OK,        11'd1},  // head after reset
      '{MODE_WALK,   11'd0,    11'd1,    1'b0, 1'b1, ST_OK,        11'd0},  // tail query
      '{MODE_INSERT, 11'd2,    11'd0,    1'b1, 1'b1, ST_NO_ANCHOR, 11'd0},
      '{MODE_INSERT, 11'd2,    11'd2047, 1'b1, 1'b1, ST_NO_ANCHOR, 11'd0},
      '{MODE_INSERT, 11'd2,    11'd9,    1'b0, 1'b1, ST_NO_ANCHOR, 11'd0},
      '{MODE_INSERT, 11'd0,    11'd1,    1'b1, 1'b1, ST_BAD_NEW,   11'd0},
      '{MODE_INSERT, 11'd1,    11'd1,    1'b0, 1'b1, ST_BAD_NEW,   11'd0},
      '{MODE_INSERT, 11'd2047, 11'd1,    1'b1, 1'b1, ST_BAD_NEW,   11'd0},
      '{MODE_INSERT, 11'd1,    11'd0,    1'b0, 1'b1, ST_NO_ANCHOR, 11'd0},  // both faults
      '{MODE_WALK,   11'd0,    11'd2047, 1'b0, 1'b1, ST_NO_QUERY,  11'd0},
      '{MODE_WALK,   11'd0,    11'd5,    1'b1, 1'b1, ST_NO_QUERY,  11'd0},
      '{MODE_INSERT, 11'd1024, 11'd1,    1'b1, 1'b1, ST_OK,        11'd0},
      '{MODE_INSERT, 11'd2,    11'd1,    1'b0, 1'b1, ST_OK,        11'd0},
      '{MODE_WALK,   11'd0,    11'd0,    1'b0, 1'b0, ST_OK,        11'd0},
      '{MODE_WALK,   11'd0,    11'd2,    1'b0, 1'b0, ST_OK,        11'd0},
      '{MODE_WALK,   11'd0,    11'd1,    1'b0, 1'b0, ST_OK,        11'd0},
      '{MODE_WALK,   11'd0,    11'd1024, 1'b0, 1'b0, ST_OK,        11'd0},
      '{MODE_INSERT, 11'd3,    11'd1024, 1'b1, 1'b0, ST_OK,        11'd0},  // new tail
      '{MODE_INSERT, 11'd4,    11'd2,    1'b0, 1'b0, ST_OK,        11'd0},  // new head
      '{MODE_INSERT, 11'd5,    11'd2,    1'b1, 1'b0, ST_OK,        11'd0},
      '{MODE_INSERT, 11'd6,    11'd1024, 1'b0, 1'b0, ST_OK,        11'd0},
      '{MODE_INSERT, 11'd1025, 11'd1,    1'b1, 1'b1, ST_BAD_NEW,   11'd0},
      '{MODE_WALK,   11'd2047, 11'd1,    1'b1, 1'b0, ST_OK,        11'd0},  // ignored fields
      '{MODE_WALK,   11'd2047, 11'd0,    1'b0, 1'b0, ST_OK,        11'd0},
      '{MODE_WALK,   11'd0,    11'd6,    1'b0, 1'b0, ST_OK,        11'd0}
    };

    in_valid        <= 1'b0;
    in_mode         <= MODE_WALK;
    in_new_node     <= '0;
    in_anchor_node  <= '0;
    in_insert_after <= 1'b0;
    rst_n           <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      w  = '{dir_tab[i].mode, dir_tab[i].new_node, dir_tab[i].anchor, dir_tab[i].ins_after};
      fr = '{dir_tab[i].st, dir_tab[i].nxt};
      send_word(w, dir_tab[i].fixed, fr);
    end
    drain_results();

    // Random words, mostly well-formed inserts and walks along the chain
    for (int n = 0; n < N_RANDOM; n++) begin
      burst = (n % 150) < 40;
      if (n == N_RANDOM / 2) drain_results();
      r = $urandom_range(0, 99);
      w.mode      = MODE_INSERT;
      w.new_node  = id_t'($urandom_range(0, 2047));
      w.anchor    = '0;
      w.ins_after = 1'($urandom_range(0, 1));
      if (r < 40) begin
        w.anchor   = pick_listed();
        w.new_node = pick_free();
      end else if (r < 65) begin
        w.mode   = MODE_WALK;
        w.anchor = cursor;
      end else if (r < 75) begin
        w.mode   = MODE_WALK;
        w.anchor = pick_listed();
      end else if (r < 85) begin
        // new id zero, out of range or already listed
        w.anchor = pick_listed();
        case ($urandom_range(0, 2))
          0: w.new_node = '0;
          1: w.new_node = id_t'($urandom_range(NODES + 1, 2047));
          default: w.new_node = pick_listed();
        endcase
      end else if (r < 93) begin
        w.anchor = ($urandom_range(0, 3) == 0) ? id_t'(0) : pick_unlisted();
      end else begin
        w.mode   = MODE_WALK;
        w.anchor = pick_unlisted();
      end
      send_word(w, 1'b0, '0);
      if (r >= 40 && r < 65) cursor = last_next;
    end
    in_valid <= 1'b0;

    // Wait for the tail of the run, then settle
    while (pending_res.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/idll_pkg.sv
src/idll_store.sv
src/idll_ctrl.sv
src/indexed_doubly_linked_list.sv
dv/testbench.sv
